// ===== design/rab_pkg.sv =====
// Shared types and constants for the ray / box slab test.
// No dependencies.
package rab_pkg;
	localparam int unsigned CRD_W = 32;
	localparam int unsigned IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

	typedef enum logic {
		OP_RAY = 1'b0,
		OP_BOX = 1'b1
	} op_t;
endpackage

// ===== design/ray_aabb_slab_test.sv =====
// Ray / axis-aligned box slab test and box overlap test, fixed point.
// Throughput one beat per cycle while the output beat is taken or empty.
// The six parallel dividers (one quotient bit per stage) set the latency.
// All stages advance together while the output beat is taken or empty.
// Reset (arst_n low) clears box registers to 0 and all valid bits.
module ray_aabb_slab_test import rab_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic signed [CRD_W-1:0] vec_a_x,
	input  logic signed [CRD_W-1:0] vec_a_y,
	input  logic signed [CRD_W-1:0] vec_a_z,
	input  logic signed [CRD_W-1:0] vec_b_x,
	input  logic signed [CRD_W-1:0] vec_b_y,
	input  logic signed [CRD_W-1:0] vec_b_z,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	output logic signed [CRD_W-1:0] distance,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [CRD_W-1:0]       cfg_data
);
	localparam int unsigned NW = CRD_W + 1 + FRAC_BITS;
	localparam int unsigned QW = NW + 1;
	localparam int unsigned LAT = NW + 1;

	logic signed [CRD_W-1:0] lo_q [3];
	logic signed [CRD_W-1:0] hi_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_X: lo_q[0] <= cfg_data;
				REG_MIN_Y: lo_q[1] <= cfg_data;
				REG_MIN_Z: lo_q[2] <= cfg_data;
				REG_MAX_X: hi_q[0] <= cfg_data;
				REG_MAX_Y: hi_q[1] <= cfg_data;
				REG_MAX_Z: hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: plane differences, zero-direction and overlap flags
	logic signed [CRD_W-1:0] va [3];
	logic signed [CRD_W-1:0] vb [3];
	assign va = '{vec_a_x, vec_a_y, vec_a_z};
	assign vb = '{vec_b_x, vec_b_y, vec_b_z};

	logic               v_s1;
	logic               op_s1;
	logic [2:0]         zero_s1;
	logic               out_s1;
	logic               ovl_s1;
	logic signed [NW-1:0] n0_s1 [3];
	logic signed [NW-1:0] n1_s1 [3];
	logic signed [CRD_W-1:0] d_s1 [3];

	logic [2:0] zr, ob, ov;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			zr[i] = (vb[i] == '0);
			ob[i] = zr[i] && (va[i] < lo_q[i] || va[i] > hi_q[i]);
			ov[i] = (va[i] < hi_q[i]) && (vb[i] > lo_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= opcode;
			zero_s1 <= zr;
			out_s1  <= |ob;
			ovl_s1  <= &ov;
			for (int i = 0; i < 3; i++) begin
				n0_s1[i] <= NW'({{(CRD_W+1){1'b0}}, {FRAC_BITS{1'b0}}}) |
					(NW'($signed({lo_q[i][CRD_W-1], lo_q[i]}) -
					$signed({va[i][CRD_W-1], va[i]})) <<< FRAC_BITS);
				n1_s1[i] <= NW'($signed({hi_q[i][CRD_W-1], hi_q[i]}) -
					$signed({va[i][CRD_W-1], va[i]})) <<< FRAC_BITS;
				d_s1[i]  <= zr[i] ? CRD_W'(1) : vb[i];
			end
		end
	end

	// dividers
	localparam int unsigned TGW = 6;
	logic signed [QW-1:0] t0 [3];
	logic signed [QW-1:0] t1 [3];
	logic [TGW-1:0] tag_d;
	logic [TGW-1:0] tag_unused [6];

	for (genvar i = 0; i < 3; i++) begin : g_ax
		rab_div #(.NW(NW), .DW(CRD_W), .TW(TGW)) u_d0 (
			.clk(clk), .adv(adv), .num(n0_s1[i]), .den(d_s1[i]),
			.tag_in({v_s1, op_s1, zero_s1, (op_s1 ? ~ovl_s1 : out_s1)}),
			.quo(t0[i]), .tag_out(tag_unused[2*i])
		);
		rab_div #(.NW(NW), .DW(CRD_W), .TW(TGW)) u_d1 (
			.clk(clk), .adv(adv), .num(n1_s1[i]), .den(d_s1[i]),
			.tag_in({v_s1, op_s1, zero_s1, (op_s1 ? ~ovl_s1 : out_s1)}),
			.quo(t1[i]), .tag_out(tag_unused[2*i+1])
		);
	end
	assign tag_d = tag_unused[0];

	// valid travels through its own reset chain
	logic [LAT-1:0] vd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd_q <= '0;
		else if (adv) vd_q <= {vd_q[LAT-2:0], v_s1};
	end

	// stage A: per-axis near/far
	logic               v_sa, op_sa, miss_sa;
	logic [2:0]         zero_sa;
	logic signed [QW-1:0] nr_sa [3];
	logic signed [QW-1:0] fr_sa [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sa <= 1'b0;
		else if (adv) v_sa <= vd_q[LAT-1];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			op_sa   <= tag_d[4];
			zero_sa <= tag_d[3:1];
			miss_sa <= tag_d[0];
			for (int i = 0; i < 3; i++) begin
				nr_sa[i] <= (t0[i] < t1[i]) ? t0[i] : t1[i];
				fr_sa[i] <= (t0[i] < t1[i]) ? t1[i] : t0[i];
			end
		end
	end

	// stage B: combine axes
	localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
	localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
	logic signed [QW-1:0] tmn, tmx;
	logic all_free;
	always_comb begin
		tmn = QMIN;
		tmx = QMAX;
		for (int i = 0; i < 3; i++) begin
			if (!zero_sa[i]) begin
				if (nr_sa[i] > tmn) tmn = nr_sa[i];
				if (fr_sa[i] < tmx) tmx = fr_sa[i];
			end
		end
		all_free = &zero_sa;
	end

	localparam logic signed [QW-1:0] S32MAX = QW'(signed'(33'sh0_7FFF_FFFF));
	localparam logic signed [QW-1:0] S32MIN = -QW'(signed'(33'sh0_8000_0000));

	logic ray_hit;
	logic signed [CRD_W-1:0] ray_dist;
	always_comb begin
		ray_hit = (tmn <= tmx) && (tmx > 0);
		if (all_free) ray_dist = {1'b1, {(CRD_W-1){1'b0}}};
		else if (tmn > S32MAX) ray_dist = {1'b0, {(CRD_W-1){1'b1}}};
		else if (tmn < S32MIN) ray_dist = {1'b1, {(CRD_W-1){1'b0}}};
		else ray_dist = tmn[CRD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_sa;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			if (op_sa == OP_BOX) begin
				hit      <= !miss_sa;
				distance <= '0;
			end else if (miss_sa) begin
				hit      <= 1'b0;
				distance <= '0;
			end else begin
				hit      <= ray_hit;
				distance <= ray_dist;
			end
		end
	end

	logic unused_ok;
	assign unused_ok = ^{tag_unused[1], tag_unused[2], tag_unused[3], tag_unused[4],
		tag_unused[5], tag_d[5]};
endmodule

// ===== design/rab_div.sv =====
// Pipelined restoring divider for one signed fixed-point slab parameter.
// Depends on rab_pkg; one quotient bit per stage, stall-aware.
module rab_div import rab_pkg::*; #(
	parameter int unsigned NW = 49,
	parameter int unsigned DW = 32,
	parameter int unsigned TW = 1
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	input  logic [TW-1:0]        tag_in,
	output logic signed [NW:0]   quo,
	output logic [TW-1:0]        tag_out
);
	logic [NW-1:0] rem_s1 [NW+1];
	logic [NW-1:0] q_s1   [NW+1];
	logic [DW-1:0] d_s1   [NW+1];
	logic          neg_s1 [NW+1];
	logic [TW-1:0] tag_s1 [NW+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1[0] <= '0;
			q_s1[0]   <= num[NW-1] ? NW'(-num) : NW'(num);
			d_s1[0]   <= den[DW-1] ? DW'(-den) : DW'(den);
			neg_s1[0] <= num[NW-1] ^ den[DW-1];
			tag_s1[0] <= tag_in;
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_st
		logic [NW:0] sh;
		logic [NW:0] df;
		assign sh = {rem_s1[k], q_s1[k][NW-1]};
		assign df = sh - (NW+1)'(d_s1[k]);
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s1[k+1] <= df[NW] ? sh[NW-1:0] : df[NW-1:0];
				q_s1[k+1]   <= {q_s1[k][NW-2:0], ~df[NW]};
				d_s1[k+1]   <= d_s1[k];
				neg_s1[k+1] <= neg_s1[k];
				tag_s1[k+1] <= tag_s1[k];
			end
		end
	end

	assign quo     = neg_s1[NW] ? -$signed({1'b0, q_s1[NW]}) : $signed({1'b0, q_s1[NW]});
	assign tag_out = tag_s1[NW];
endmodule

// ===== design/rab_checker.sv =====
// Port-level checker for ray_aabb_slab_test, bound to the top level.
// Depends on rab_pkg.
module rab_checker import rab_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic hit,
	input logic signed [CRD_W-1:0] distance
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance) && $stable(hit))
		else $error("output beat changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid || arst_n)
		else $error("valid out of reset");
endmodule

bind ray_aabb_slab_test rab_checker u_rab_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .distance(distance)
);
